// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the positional stack engine.
// Used by every module under rtl except pse_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  // fixed field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 9;

  // opcodes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_DELRUN = 3'd4;
  localparam logic [2:0] OP_SEARCH = 3'd5;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // command beat
  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
    logic [PosW-1:0]         run_length;
  } cmd_t;

  // result beat
  typedef struct packed {
    status_e                 status;
    logic                    found;
    logic signed [DataW-1:0] top_value;
    logic [CountW-1:0]       entry_count;
  } rsp_t;

  // work plan for one command, indexes at full count width
  typedef struct packed {
    status_e           status;
    logic              search;
    logic              move_up;
    logic              wr_val;
    logic [CountW-1:0] src;
    logic [CountW-1:0] dst;
    logic [CountW-1:0] moves;
    logic [CountW-1:0] wr_idx;
    logic [CountW-1:0] new_count;
  } plan_t;

endpackage

`default_nettype wire

// ===== rtl/pse_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/pse_dec.sv =====
// Command decoder: checks a command against the current count and plans
// the entry moves, the value write and the new count. Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pse_dec #(
  parameter int unsigned DEPTH = 16
) (
  input  wire pse_pkg::cmd_t                    cmd_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]       count_i,
  output pse_pkg::plan_t                        plan_o
);

  logic [pse_pkg::CountW-1:0] cnt;
  logic [pse_pkg::CountW-1:0] pos;
  logic [pse_pkg::CountW-1:0] run;
  logic [pse_pkg::CountW-1:0] ins_p;
  logic [pse_pkg::CountW-1:0] del_p;
  logic [pse_pkg::CountW-1:0] num;
  logic                       full;
  logic                       pos_zero;

  // clamped positions
  always_comb begin
    cnt      = pse_pkg::CountW'(count_i);
    pos      = pse_pkg::CountW'(cmd_i.position);
    run      = pse_pkg::CountW'(cmd_i.run_length);
    full     = (cnt >= pse_pkg::CountW'(DEPTH));
    pos_zero = (cmd_i.position == '0);
    ins_p    = (cmd_i.opcode == pse_pkg::OP_PUSH || pos > cnt) ?
               cnt + pse_pkg::CountW'(1) : pos;
    del_p    = (cmd_i.opcode == pse_pkg::OP_POP || pos > cnt) ? cnt : pos;
    num      = (cmd_i.opcode != pse_pkg::OP_DELRUN) ? pse_pkg::CountW'(1) :
               ((run > del_p) ? del_p : run);
  end

  // plan per opcode
  always_comb begin
    plan_o           = '0;
    plan_o.status    = pse_pkg::ST_OK;
    plan_o.new_count = cnt;
    unique case (cmd_i.opcode) inside
      pse_pkg::OP_PUSH, pse_pkg::OP_INSERT: begin
        if (cmd_i.opcode == pse_pkg::OP_INSERT && pos_zero) begin
          plan_o.status = pse_pkg::ST_BADPOS;
        end else if (full) begin
          plan_o.status = pse_pkg::ST_FULL;
        end else begin
          // shift entries at and above the slot up by one, top first
          plan_o.moves     = cnt + pse_pkg::CountW'(1) - ins_p;
          plan_o.src       = cnt - pse_pkg::CountW'(1);
          plan_o.dst       = cnt;
          plan_o.move_up   = 1'b0;
          plan_o.wr_val    = 1'b1;
          plan_o.wr_idx    = ins_p - pse_pkg::CountW'(1);
          plan_o.new_count = cnt + pse_pkg::CountW'(1);
        end
      end
      pse_pkg::OP_POP, pse_pkg::OP_DELETE, pse_pkg::OP_DELRUN: begin
        if (cmd_i.opcode != pse_pkg::OP_POP && pos_zero) begin
          plan_o.status = pse_pkg::ST_BADPOS;
        end else if (cnt == '0) begin
          plan_o.status = pse_pkg::ST_EMPTY;
        end else begin
          // close the gap: entries above the run move down by num, bottom first
          plan_o.moves     = (num == '0) ? '0 : cnt - del_p;
          plan_o.src       = del_p;
          plan_o.dst       = del_p - num;
          plan_o.move_up   = 1'b1;
          plan_o.new_count = cnt - num;
        end
      end
      pse_pkg::OP_SEARCH: begin
        plan_o.search = 1'b1;
        plan_o.moves  = cnt;
        plan_o.src    = '0;
      end
      default: begin
        plan_o.status = pse_pkg::ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pse_seq.sv =====
// Sequencer: walks the entry memory one read and one write at a time to
// shift, write, scan and fetch the top entry. Depends on pse_pkg and pse_ram.
`timescale 1ns / 1ps
`default_nettype none

module pse_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire pse_pkg::plan_t                     plan_i,
  input  wire logic signed [pse_pkg::DataW-1:0]   value_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic [$clog2(DEPTH+1)-1:0]              count_o,
  output pse_pkg::status_e                        status_o,
  output logic                                    found_o,
  output logic [pse_pkg::DataW-1:0]               rdata_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MV_RD   = 3'd1;
  localparam logic [2:0] S_MV_WR   = 3'd2;
  localparam logic [2:0] S_WR_VAL  = 3'd3;
  localparam logic [2:0] S_SR_RD   = 3'd4;
  localparam logic [2:0] S_SR_CMP  = 3'd5;
  localparam logic [2:0] S_TOP_RD  = 3'd6;
  localparam logic [2:0] S_TOP_DAT = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            moves_q, moves_d;
  logic [IW-1:0]            src_q, src_d;
  logic [IW-1:0]            dst_q, dst_d;
  logic [IW-1:0]            wr_idx_q, wr_idx_d;
  logic                     up_q, up_d;
  logic                     wr_val_q, wr_val_d;
  logic                     found_q, found_d;
  pse_pkg::status_e         status_q, status_d;
  logic [pse_pkg::DataW-1:0] val_q, val_d;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [pse_pkg::DataW-1:0] ram_wdata;
  logic [IW-1:0]             ram_raddr;
  logic [pse_pkg::DataW-1:0] ram_rdata;
  logic [CW-1:0]             top_idx;
  logic [CW-1:0]             plan_moves;

  assign top_idx    = count_q - CW'(1);
  assign plan_moves = plan_i.moves[CW-1:0];

  // entry storage
  pse_ram #(
    .Width(pse_pkg::DataW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = ram_rdata;
    ram_raddr = (state_q == S_TOP_RD) ? top_idx[IW-1:0] : src_q;
    if (state_q == S_MV_WR) begin
      ram_we = 1'b1;
    end else if (state_q == S_WR_VAL) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx_q;
      ram_wdata = val_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    moves_d  = moves_q;
    src_d    = src_q;
    dst_d    = dst_q;
    wr_idx_d = wr_idx_q;
    up_d     = up_q;
    wr_val_d = wr_val_q;
    found_d  = found_q;
    status_d = status_q;
    val_d    = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          count_d  = plan_i.new_count[CW-1:0];
          moves_d  = plan_moves;
          src_d    = plan_i.src[IW-1:0];
          dst_d    = plan_i.dst[IW-1:0];
          wr_idx_d = plan_i.wr_idx[IW-1:0];
          up_d     = plan_i.move_up;
          wr_val_d = plan_i.wr_val;
          status_d = plan_i.status;
          val_d    = value_i;
          found_d  = 1'b0;
          if (plan_i.search && plan_moves != '0) begin
            state_d = S_SR_RD;
          end else if (plan_moves != '0) begin
            state_d = S_MV_RD;
          end else if (plan_i.wr_val) begin
            state_d = S_WR_VAL;
          end else begin
            state_d = S_TOP_RD;
          end
        end
      end
      S_MV_RD: begin
        state_d = S_MV_WR;
      end
      S_MV_WR: begin
        // one entry moved per read/write pair
        src_d   = up_q ? src_q + IW'(1) : src_q - IW'(1);
        dst_d   = up_q ? dst_q + IW'(1) : dst_q - IW'(1);
        moves_d = moves_q - CW'(1);
        if (moves_q == CW'(1)) begin
          state_d = wr_val_q ? S_WR_VAL : S_TOP_RD;
        end else begin
          state_d = S_MV_RD;
        end
      end
      S_WR_VAL: begin
        state_d = S_TOP_RD;
      end
      S_SR_RD: begin
        state_d = S_SR_CMP;
      end
      S_SR_CMP: begin
        // compare one entry, bottom up
        if (ram_rdata == val_q) begin
          found_d = 1'b1;
        end
        src_d   = src_q + IW'(1);
        moves_d = moves_q - CW'(1);
        state_d = (moves_q == CW'(1)) ? S_TOP_RD : S_SR_RD;
      end
      S_TOP_RD: begin
        state_d = S_TOP_DAT;
      end
      S_TOP_DAT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      moves_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      moves_q <= moves_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    wr_idx_q <= wr_idx_d;
    up_q     <= up_d;
    wr_val_q <= wr_val_d;
    found_q  <= found_d;
    status_q <= status_d;
    val_q    <= val_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_TOP_DAT);
  assign count_o  = count_q;
  assign status_o = status_q;
  assign found_o  = found_q;
  assign rdata_o  = ram_rdata;

endmodule

`default_nettype wire

// ===== rtl/positional_stack_engine_core.sv =====
// Top level of the positional stack engine: decoder, sequencer and result beat.
// Depends on pse_pkg, pse_dec, pse_seq and pse_ram.
`timescale 1ns / 1ps
`default_nettype none

// Bounded stack of DEPTH signed 32-bit words with push, pop, insert and delete
// at a 1-based position from the bottom, delete of a run, and search. A command
// beat is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with done_o high, and the receiver cannot stall
// it. The words live in one synchronous RAM with one write and one registered
// read port, so every entry that moves is read and then written back.
// After accept, the entries that shift (those at or above the insert slot, or
// above the deleted ones) move first, push and insert then write the value,
// and the top entry is read for the result beat; a search instead compares the
// stored entries bottom up before the top read. Errors, unused opcodes, and
// search or delete on nothing to move go to the top read. busy stays high until
// the result beat has been shown; no clearing pass is needed after reset.
module positional_stack_engine_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire pse_pkg::cmd_t cmd_i,
  output logic               done_o,
  output pse_pkg::rsp_t      rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                      accept;
  logic                      seq_busy;
  logic [CW-1:0]             count;
  pse_pkg::plan_t            plan;
  pse_pkg::status_e          status;
  logic                      found;
  logic [pse_pkg::DataW-1:0] rdata;

  // command beat handshake
  assign accept = start & ~seq_busy;
  assign busy   = seq_busy;

  pse_dec #(
    .DEPTH(DEPTH)
  ) u_dec (
    .cmd_i  (cmd_i),
    .count_i(count),
    .plan_o (plan)
  );

  pse_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .plan_i  (plan),
    .value_i (cmd_i.value),
    .busy_o  (seq_busy),
    .done_o  (done_o),
    .count_o (count),
    .status_o(status),
    .found_o (found),
    .rdata_o (rdata)
  );

  // result beat, top reads as zero on an empty stack
  always_comb begin
    rsp_o             = '0;
    rsp_o.status      = status;
    rsp_o.found       = found;
    rsp_o.top_value   = (count == '0) ? '0 : $signed(rdata);
    rsp_o.entry_count = pse_pkg::CountW'(count);
  end

endmodule

`default_nettype wire

// ===== tb/positional_stack_engine_core_tb.sv =====
// Self-checking testbench for positional_stack_engine_core: directed and random
// command beats, each result beat checked against an in-bench stack model.
// Depends on pse_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module positional_stack_engine_core_tb;
  import pse_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RAND_PHASE   = 134;

  // codes the package leaves unnamed
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  cmd_t  cmd_i;
  logic  done_o;
  rsp_t  rsp_o;

  // model of the stack contents, updated at each accepted command beat
  logic signed [DataW-1:0] stk_words [DEPTH];
  int                      stk_cnt;
  rsp_t                    expected_rsp_q[$];

  int          err_cnt = 0;
  int unsigned idle_pct;
  int unsigned cycle_cnt = 0;
  bit          fill_mode;

  positional_stack_engine_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // apply one command to the stack model and return the result it causes
  function automatic rsp_t apply_cmd(input cmd_t c);
    rsp_t r;
    int   p;
    int   num;
    int   i;
    r.status = ST_OK;
    r.found  = 1'b0;
    if ((c.opcode == OP_INSERT || c.opcode == OP_DELETE || c.opcode == OP_DELRUN) &&
        c.position == '0) begin
      r.status = ST_BADPOS;
    end else if (c.opcode == OP_PUSH || c.opcode == OP_INSERT) begin
      if (stk_cnt >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        p = (c.opcode == OP_PUSH) ? stk_cnt + 1 : int'(c.position);
        if (p > stk_cnt + 1) p = stk_cnt + 1;
        for (i = stk_cnt; i > p - 1; i--) stk_words[i] = stk_words[i-1];
        stk_words[p-1] = c.value;
        stk_cnt++;
      end
    end else if (c.opcode == OP_POP || c.opcode == OP_DELETE || c.opcode == OP_DELRUN) begin
      if (stk_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        p = (c.opcode == OP_POP) ? stk_cnt : int'(c.position);
        if (p > stk_cnt) p = stk_cnt;
        num = 1;
        if (c.opcode == OP_DELRUN) num = (int'(c.run_length) > p) ? p : int'(c.run_length);
        for (i = p - num; i + num < stk_cnt; i++) stk_words[i] = stk_words[i+num];
        stk_cnt -= num;
      end
    end else if (c.opcode == OP_SEARCH) begin
      for (i = 0; i < stk_cnt; i++) if (stk_words[i] == c.value) r.found = 1'b1;
    end
    r.top_value   = (stk_cnt > 0) ? stk_words[stk_cnt-1] : '0;
    r.entry_count = stk_cnt[CountW-1:0];
    return r;
  endfunction

  function automatic cmd_t make_cmd(input logic [2:0] op, input logic signed [DataW-1:0] val,
                                    input logic [PosW-1:0] pos, input logic [PosW-1:0] run);
    cmd_t c;
    c.opcode     = op;
    c.value      = val;
    c.position   = pos;
    c.run_length = run;
    return c;
  endfunction

  // send one command beat; idle cycles carry random junk with start low
  task automatic send_cmd(input cmd_t c);
    cmd_t junk;
    @(negedge clk_i);
    while (idle_pct != 0 && (busy || $urandom_range(99) < idle_pct)) begin
      junk.opcode     = 3'($urandom_range(7));
      junk.value      = $urandom;
      junk.position   = PosW'($urandom_range(255));
      junk.run_length = PosW'($urandom_range(255));
      start = 1'b0;
      cmd_i = junk;
      @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rsp_q.push_back(apply_cmd(c));
  endtask

  // check each result beat against the oldest expectation
  always @(posedge clk_i) begin : chk_blk
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat, expected none, actual status %0d count %0d",
                 $time, rsp_o.status, rsp_o.entry_count);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.status !== want.status) begin
          err_cnt++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, rsp_o.status);
        end
        if (rsp_o.found !== want.found) begin
          err_cnt++;
          $display("%0t: found mismatch, expected %0d actual %0d",
                   $time, want.found, rsp_o.found);
        end
        if (rsp_o.top_value !== want.top_value) begin
          err_cnt++;
          $display("%0t: top_value mismatch, expected %0d actual %0d",
                   $time, want.top_value, rsp_o.top_value);
        end
        if (rsp_o.entry_count !== want.entry_count) begin
          err_cnt++;
          $display("%0t: entry_count mismatch, expected %0d actual %0d",
                   $time, want.entry_count, rsp_o.entry_count);
        end
      end
    end
  end

  // commands on an empty stack, bad position wins over empty
  task automatic test_empty_stack();
    send_cmd(make_cmd(OP_POP, 32'sd0, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_DELETE, 32'sd0, 8'd1, 8'd0));
    send_cmd(make_cmd(OP_DELRUN, 32'sd0, 8'd1, 8'd3));
    send_cmd(make_cmd(OP_SEARCH, 32'sd0, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_DELETE, 32'sd0, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_INSERT, 32'sd7, 8'd0, 8'd0));
  endtask

  // extreme words through push, search and pop
  task automatic test_push_extremes();
    send_cmd(make_cmd(OP_PUSH, 32'sh7fffffff, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_PUSH, 32'sh80000000, 8'd255, 8'd255));
    send_cmd(make_cmd(OP_PUSH, -32'sd1, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_PUSH, 32'sd0, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_SEARCH, 32'sh80000000, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_SEARCH, 32'sd5, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_POP, 32'sd0, 8'd0, 8'd0));
  endtask

  // insert and delete at the bottom, in the middle and above the count
  task automatic test_positions();
    send_cmd(make_cmd(OP_INSERT, 32'sd11, 8'd1, 8'd0));
    send_cmd(make_cmd(OP_INSERT, 32'sd22, 8'd255, 8'd0));
    send_cmd(make_cmd(OP_INSERT, 32'sd33, 8'd2, 8'd0));
    send_cmd(make_cmd(OP_DELETE, 32'sd0, 8'd1, 8'd0));
    send_cmd(make_cmd(OP_DELETE, 32'sd0, 8'd200, 8'd0));
    send_cmd(make_cmd(OP_DELETE, 32'sd0, 8'd2, 8'd0));
  endtask

  // run of zero, run clamped at the bottom, run above the count
  task automatic test_delete_run();
    send_cmd(make_cmd(OP_DELRUN, 32'sd0, 8'd3, 8'd0));
    send_cmd(make_cmd(OP_DELRUN, 32'sd0, 8'd2, 8'd255));
    send_cmd(make_cmd(OP_PUSH, 32'sd44, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_DELRUN, 32'sd0, 8'd255, 8'd1));
  endtask

  // spare opcodes leave the stack alone
  task automatic test_spare_opcodes();
    send_cmd(make_cmd(OP_PUSH, 32'sd55, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_SPARE6, $urandom, 8'd1, 8'd1));
    send_cmd(make_cmd(OP_SPARE7, $urandom, 8'd255, 8'd255));
  endtask

  // fill up, overflow both ways, then clear everything with one run
  task automatic test_full_stack();
    while (stk_cnt < DEPTH) send_cmd(make_cmd(OP_PUSH, $urandom, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_PUSH, 32'sd1, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_INSERT, 32'sd2, 8'd1, 8'd0));
    send_cmd(make_cmd(OP_INSERT, 32'sd3, 8'd0, 8'd0));
    send_cmd(make_cmd(OP_SEARCH, stk_words[0], 8'd0, 8'd0));
    send_cmd(make_cmd(OP_DELRUN, 32'sd0, 8'd255, 8'd255));
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: return (stk_cnt > 0) ? stk_words[$urandom_range(stk_cnt - 1)] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(99);
    // drift toward full, then toward empty, so both ends get exercised
    if (stk_cnt >= DEPTH && $urandom_range(3) == 0) fill_mode = 1'b0;
    if (stk_cnt == 0 && $urandom_range(3) == 0) fill_mode = 1'b1;
    if (r < 3) return ($urandom_range(1) != 0) ? OP_SPARE6 : OP_SPARE7;
    if (r < 15) return OP_SEARCH;
    if ((r < 75) == fill_mode) return ($urandom_range(1) != 0) ? OP_PUSH : OP_INSERT;
    case ($urandom_range(4))
      0, 1: return OP_POP;
      2, 3: return OP_DELETE;
      default: return OP_DELRUN;
    endcase
  endfunction

  // random commands with mostly legal positions and short runs
  task automatic test_random_ops(input int unsigned n, input int unsigned pct);
    cmd_t        c;
    int unsigned r;
    idle_pct = pct;
    repeat (n) begin
      c.opcode = pick_opcode();
      c.value  = pick_value();
      r = $urandom_range(19);
      if (r == 0)      c.position = '0;
      else if (r < 3)  c.position = PosW'($urandom_range(255));
      else             c.position = PosW'($urandom_range(stk_cnt + 1, 1));
      if ($urandom_range(9) == 0) c.run_length = PosW'($urandom_range(255));
      else                        c.run_length = PosW'($urandom_range(4));
      send_cmd(c);
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd_i     = '0;
    idle_pct  = 0;
    fill_mode = 1'b1;
    stk_cnt   = 0;
    for (int i = 0; i < DEPTH; i++) stk_words[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_stack();
    test_push_extremes();
    test_positions();
    test_delete_run();
    test_spare_opcodes();
    test_full_stack();
    test_random_ops(RAND_PHASE, 0);
    test_random_ops(RAND_PHASE, 68);
    test_random_ops(RAND_PHASE, 11);

    @(negedge clk_i);
    start = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
